### src/line_line_closest_points_core_assert.svh
// Assertion macros for the closest-points core.
`ifndef LINE_LINE_CLOSEST_POINTS_CORE_ASSERT_SVH
`define LINE_LINE_CLOSEST_POINTS_CORE_ASSERT_SVH

// Same-cycle implication, reset masks the check.
`define LLCP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Fixed-delay implication, reset masks the check.
`define LLCP_ASSERT_DELAY(label, clk, rst, ante, lat, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##lat (cons)) \
      else $error(msg);

`endif

### src/llcp_pkg.sv
// Shared constants and helpers for the closest-points core.
package llcp_pkg;
   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS = 16;
   localparam int THR_WIDTH = 16;
   localparam int DENOM_SHIFT = 3 * FRAC_BITS;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   // register select is paddr[2]
   localparam logic REG_ZERO_THRESHOLD = 1'b0;
   // divider stages beyond the quotient steps: abs, operand prep, range check, sign, add/sat
   localparam int DIV_OVERHEAD = 5;

   // quotient bits resolved by the divider; anything larger saturates anyway
   function automatic int quot_bits(input int coord_width);
      return coord_width + 1;
   endfunction
endpackage

### src/llcp_div.sv
// Pipelined rounding divider with offset add and saturation, one quotient bit per stage.
module llcp_div #(
   parameter int COORD_WIDTH = llcp_pkg::COORD_WIDTH_DEFAULT,
   parameter int NUM_WIDTH   = 5 * llcp_pkg::COORD_WIDTH_DEFAULT + 10,
   parameter int DEN_WIDTH   = 4 * llcp_pkg::COORD_WIDTH_DEFAULT + 9
) (
   input  logic                          clock,
   input  logic signed [NUM_WIDTH-1:0]   n,
   input  logic        [DEN_WIDTH-1:0]   dmag,
   input  logic                          dneg,
   input  logic signed [COORD_WIDTH-1:0] base,
   output logic signed [COORD_WIDTH-1:0] result
);
   import llcp_pkg::*;

   localparam int QB = quot_bits(COORD_WIDTH);
   localparam int RW = NUM_WIDTH + 2;
   localparam int SW = QB + 2;
   localparam logic signed [SW-1:0] SMAX = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] OMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] OMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // stage 0: magnitudes and quotient sign
   logic [NUM_WIDTH-1:0]          nmag_ff;
   logic [DEN_WIDTH-1:0]          dmag0_ff;
   logic                          neg0_ff;
   logic signed [COORD_WIDTH-1:0] base0_ff;

   always_ff @(posedge clock) begin
      nmag_ff  <= n[NUM_WIDTH-1] ? (~n + 1'b1) : n;
      dmag0_ff <= dmag;
      neg0_ff  <= n[NUM_WIDTH-1] ^ dneg;
      base0_ff <= base;
   end

   // stage 1: round half away from zero as floor((2|n| + |d|) / (2|d|))
   logic [RW-1:0]                 x_ff;
   logic [DEN_WIDTH:0]            y1_ff;
   logic                          neg1_ff;
   logic signed [COORD_WIDTH-1:0] base1_ff;

   always_ff @(posedge clock) begin
      x_ff     <= (RW'(nmag_ff) << 1) + RW'(dmag0_ff);
      y1_ff    <= {dmag0_ff, 1'b0};
      neg1_ff  <= neg0_ff;
      base1_ff <= base0_ff;
   end

   // stage 2 feeds index QB; steps count down to index 0
   logic [RW-1:0]                 rem_ff  [0:QB];
   logic [QB-1:0]                 quo_ff  [0:QB];
   logic [DEN_WIDTH:0]            yv_ff   [1:QB];
   logic                          neg_ff  [0:QB];
   logic                          ovf_ff  [0:QB];
   logic signed [COORD_WIDTH-1:0] base_ff [0:QB];

   always_ff @(posedge clock) begin
      rem_ff[QB]  <= x_ff;
      quo_ff[QB]  <= '0;
      yv_ff[QB]   <= y1_ff;
      neg_ff[QB]  <= neg1_ff;
      ovf_ff[QB]  <= x_ff >= (RW'(y1_ff) << QB);
      base_ff[QB] <= base1_ff;
   end

   for (genvar i = 0; i < QB; i++) begin : g_step
      logic [RW-1:0] sh;
      logic          fit;
      logic [QB-1:0] quo_in;

      assign sh  = RW'(yv_ff[i+1]) << i;
      assign fit = rem_ff[i+1] >= sh;

      always_comb begin
         quo_in    = quo_ff[i+1];
         quo_in[i] = fit;
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= fit ? (rem_ff[i+1] - sh) : rem_ff[i+1];
         quo_ff[i]  <= quo_in;
         neg_ff[i]  <= neg_ff[i+1];
         ovf_ff[i]  <= ovf_ff[i+1];
         base_ff[i] <= base_ff[i+1];
      end

      if (i > 0) begin : g_ycarry
         always_ff @(posedge clock) begin
            yv_ff[i] <= yv_ff[i+1];
         end
      end
   end

   // apply sign
   logic [QB:0]                   qpos;
   logic signed [QB:0]            qs_ff;
   logic                          negf_ff;
   logic                          ovff_ff;
   logic signed [COORD_WIDTH-1:0] basef_ff;

   assign qpos = {1'b0, quo_ff[0]};

   always_ff @(posedge clock) begin
      qs_ff    <= neg_ff[0] ? (~qpos + 1'b1) : qpos;
      negf_ff  <= neg_ff[0];
      ovff_ff  <= ovf_ff[0];
      basef_ff <= base_ff[0];
   end

   // add offset and clamp
   logic signed [SW-1:0]          sum;
   logic signed [COORD_WIDTH-1:0] result_in;
   logic signed [COORD_WIDTH-1:0] result_ff;

   assign sum = SW'(basef_ff) + SW'(qs_ff);

   always_comb begin
      priority if (ovff_ff) begin
         result_in = negf_ff ? OMIN : OMAX;
      end else if (sum > SMAX) begin
         result_in = OMAX;
      end else if (sum < SMIN) begin
         result_in = OMIN;
      end else begin
         result_in = sum[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;
endmodule

### src/line_line_closest_points_core.sv
// Closest points between two 3D lines: top level, front pipeline and eight dividers.
//
// Takes one pair of lines per clock (busy never rises) and returns one result per
// item, in order. Eight front stages form the differences, dot products, the
// wide cross terms and the numerators; the dividers then resolve one quotient
// bit per stage over COORD_WIDTH + 1 stages. Results come out on a one-cycle
// rsp_valid strobe and cannot be held off by the receiver. zero_threshold sits
// at byte address 0; the user must see that it is written only while the
// pipeline is empty, which the block itself does not enforce.
`include "line_line_closest_points_core_assert.svh"

module line_line_closest_points_core #(
   parameter int COORD_WIDTH = llcp_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_WIDTH-1:0]         req_line_a_start_x,
   input  logic signed [COORD_WIDTH-1:0]         req_line_a_start_y,
   input  logic signed [COORD_WIDTH-1:0]         req_line_a_start_z,
   input  logic signed [COORD_WIDTH-1:0]         req_line_a_end_x,
   input  logic signed [COORD_WIDTH-1:0]         req_line_a_end_y,
   input  logic signed [COORD_WIDTH-1:0]         req_line_a_end_z,
   input  logic signed [COORD_WIDTH-1:0]         req_line_b_start_x,
   input  logic signed [COORD_WIDTH-1:0]         req_line_b_start_y,
   input  logic signed [COORD_WIDTH-1:0]         req_line_b_start_z,
   input  logic signed [COORD_WIDTH-1:0]         req_line_b_end_x,
   input  logic signed [COORD_WIDTH-1:0]         req_line_b_end_y,
   input  logic signed [COORD_WIDTH-1:0]         req_line_b_end_z,
   output logic                                  rsp_valid,
   output logic                                  rsp_valid_res,
   output logic signed [COORD_WIDTH-1:0]         rsp_near_a_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_near_a_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_near_a_z,
   output logic signed [COORD_WIDTH-1:0]         rsp_near_b_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_near_b_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_near_b_z,
   output logic signed [COORD_WIDTH-1:0]         rsp_param_a,
   output logic signed [COORD_WIDTH-1:0]         rsp_param_b,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [llcp_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [llcp_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [llcp_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                  pready
);
   import llcp_pkg::*;

   localparam int DW    = COORD_WIDTH + 1;        // coordinate differences
   localparam int PRW   = 2 * DW;                 // one dot-product term
   localparam int PW    = PRW + 2;                // dot products
   localparam int H     = PW / 2;
   localparam int HW    = PW - H;
   localparam int HHW   = 2 * HW;
   localparam int HLW   = HW + H + 1;
   localparam int LLW   = 2 * H;
   localparam int TW    = 2 * PW;                 // cross terms
   localparam int NW    = TW + 1;                 // denominator, numerators
   localparam int CH    = COORD_WIDTH;            // numerator chunk
   localparam int K     = (NW + CH - 1) / CH;
   localparam int TOPW  = NW - (K - 1) * CH;
   localparam int PPW   = CH + 1 + DW;
   localparam int MW    = NW + DW;                // scaled numerators
   localparam int DL    = quot_bits(COORD_WIDTH) + DIV_OVERHEAD;
   localparam int FRONT = 8;
   localparam int NREG  = FRONT + DL;

   typedef struct packed {
      logic [2:0][COORD_WIDTH-1:0] a0;
      logic [2:0][COORD_WIDTH-1:0] b0;
      logic [2:0][DW-1:0]          b;
      logic [2:0][DW-1:0]          c;
      logic                        degen;
   } side_type;

   // ---------------- configuration ----------------
   logic [THR_WIDTH-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ZERO_THRESHOLD)) begin
         thr_ff <= pwdata[THR_WIDTH-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_ZERO_THRESHOLD) ? CSR_DATA_WIDTH'(thr_ff) : '0;
   assign busy   = 1'b0;

   // ---------------- valid pipeline ----------------
   logic vld_ff [0:NREG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NREG; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start && !busy;
         for (int s = 1; s < NREG; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // ---------------- stage 1: differences ----------------
   logic signed [COORD_WIDTH-1:0] pa0 [3];
   logic signed [COORD_WIDTH-1:0] pa1 [3];
   logic signed [COORD_WIDTH-1:0] pb0 [3];
   logic signed [COORD_WIDTH-1:0] pb1 [3];

   assign pa0[0] = req_line_a_start_x;
   assign pa0[1] = req_line_a_start_y;
   assign pa0[2] = req_line_a_start_z;
   assign pa1[0] = req_line_a_end_x;
   assign pa1[1] = req_line_a_end_y;
   assign pa1[2] = req_line_a_end_z;
   assign pb0[0] = req_line_b_start_x;
   assign pb0[1] = req_line_b_start_y;
   assign pb0[2] = req_line_b_start_z;
   assign pb1[0] = req_line_b_end_x;
   assign pb1[1] = req_line_b_end_y;
   assign pb1[2] = req_line_b_end_z;

   side_type           s1_in;
   logic [2:0][DW-1:0] a1_in;
   logic [2:0][DW-1:0] a1_ff;
   side_type           side_ff [1:8];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s1_in.a0[k] = pa0[k];
         s1_in.b0[k] = pb0[k];
         s1_in.b[k]  = DW'(pb1[k]) - DW'(pb0[k]);
         s1_in.c[k]  = DW'(pa1[k]) - DW'(pa0[k]);
         a1_in[k]    = DW'(pa0[k]) - DW'(pb0[k]);
      end
      s1_in.degen = 1'b0;
   end

   // ---------------- stage 2: term products, degenerate check ----------------
   function automatic logic is_small(input logic [DW-1:0] v, input logic [THR_WIDTH-1:0] t);
      logic [DW-1:0] m;
      m = v[DW-1] ? (~v + 1'b1) : v;
      return m <= DW'(t);
   endfunction

   logic signed [PRW-1:0] prd_in [5][3];
   logic signed [PRW-1:0] prd_ff [5][3];
   side_type              s2_in;

   // product order: ab, bc, ac, bb, cc
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prd_in[0][k] = PRW'($signed(a1_ff[k])) * PRW'($signed(side_ff[1].b[k]));
         prd_in[1][k] = PRW'($signed(side_ff[1].b[k])) * PRW'($signed(side_ff[1].c[k]));
         prd_in[2][k] = PRW'($signed(a1_ff[k])) * PRW'($signed(side_ff[1].c[k]));
         prd_in[3][k] = PRW'($signed(side_ff[1].b[k])) * PRW'($signed(side_ff[1].b[k]));
         prd_in[4][k] = PRW'($signed(side_ff[1].c[k])) * PRW'($signed(side_ff[1].c[k]));
      end
      s2_in       = side_ff[1];
      s2_in.degen = (is_small(side_ff[1].b[0], thr_ff) && is_small(side_ff[1].b[1], thr_ff)
                     && is_small(side_ff[1].b[2], thr_ff))
                 || (is_small(side_ff[1].c[0], thr_ff) && is_small(side_ff[1].c[1], thr_ff)
                     && is_small(side_ff[1].c[2], thr_ff));
   end

   // ---------------- stage 3: dot products ----------------
   logic signed [PW-1:0] dot_in [5];
   logic signed [PW-1:0] dot_ff [5];

   always_comb begin
      for (int j = 0; j < 5; j++) begin
         dot_in[j] = PW'(prd_ff[j][0]) + PW'(prd_ff[j][1]) + PW'(prd_ff[j][2]);
      end
   end

   // ---------------- stage 4: half-split partial products ----------------
   // pairs: cc*bb, bc*bc, ab*bc, ac*bb, ab*cc, bc*ac
   logic signed [PW-1:0]  xop [6];
   logic signed [PW-1:0]  yop [6];
   logic signed [HHW-1:0] hh_in [6];
   logic signed [HLW-1:0] hl_in [6];
   logic signed [HLW-1:0] lh_in [6];
   logic [LLW-1:0]        ll_in [6];
   logic signed [HHW-1:0] hh_ff [6];
   logic signed [HLW-1:0] hl_ff [6];
   logic signed [HLW-1:0] lh_ff [6];
   logic [LLW-1:0]        ll_ff [6];

   assign xop[0] = dot_ff[4];
   assign yop[0] = dot_ff[3];
   assign xop[1] = dot_ff[1];
   assign yop[1] = dot_ff[1];
   assign xop[2] = dot_ff[0];
   assign yop[2] = dot_ff[1];
   assign xop[3] = dot_ff[2];
   assign yop[3] = dot_ff[3];
   assign xop[4] = dot_ff[0];
   assign yop[4] = dot_ff[4];
   assign xop[5] = dot_ff[1];
   assign yop[5] = dot_ff[2];

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         hh_in[j] = HHW'($signed(xop[j][PW-1:H])) * HHW'($signed(yop[j][PW-1:H]));
         hl_in[j] = HLW'($signed(xop[j][PW-1:H])) * HLW'($signed({1'b0, yop[j][H-1:0]}));
         lh_in[j] = HLW'($signed({1'b0, xop[j][H-1:0]})) * HLW'($signed(yop[j][PW-1:H]));
         ll_in[j] = LLW'(xop[j][H-1:0]) * LLW'(yop[j][H-1:0]);
      end
   end

   // ---------------- stage 5: recombine ----------------
   logic signed [TW-1:0] cross_in [6];
   logic signed [TW-1:0] cross_ff [6];

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         cross_in[j] = (TW'(hh_ff[j]) <<< (2 * H)) + (TW'(hl_ff[j]) <<< H)
                     + (TW'(lh_ff[j]) <<< H) + TW'(ll_ff[j]);
      end
   end

   // ---------------- stage 6: denominator and numerators ----------------
   logic signed [NW-1:0] denom6_ff;
   logic signed [NW-1:0] numa6_ff;
   logic signed [NW-1:0] numb6_ff;

   // ---------------- stage 7: |denom|, chunked numerator products ----------------
   logic [NW-1:0]         dmag7_ff;
   logic                  dneg7_ff;
   logic signed [NW-1:0]  numa7_ff;
   logic signed [NW-1:0]  numb7_ff;
   logic signed [PPW-1:0] pp_in [6][K];
   logic signed [PPW-1:0] pp_ff [6][K];

   for (genvar j = 0; j < 6; j++) begin : g_lane
      logic signed [NW-1:0] mop;
      logic signed [DW-1:0] sop;

      if (j < 3) begin : g_numa
         assign mop = numa6_ff;
         assign sop = $signed(side_ff[6].c[j]);
      end else begin : g_numb
         assign mop = numb6_ff;
         assign sop = $signed(side_ff[6].b[j-3]);
      end

      for (genvar k = 0; k < K; k++) begin : g_chunk
         if (k < K - 1) begin : g_low
            assign pp_in[j][k] = PPW'($signed({1'b0, mop[k*CH +: CH]})) * PPW'(sop);
         end else begin : g_top
            assign pp_in[j][k] = PPW'($signed(mop[NW-1:(K-1)*CH])) * PPW'(sop);
         end
      end
   end

   // ---------------- stage 8: full products, parallel check ----------------
   logic signed [MW-1:0] prod_in [6];
   logic signed [MW-1:0] prod_ff [6];
   logic signed [MW-1:0] npar_ff [2];
   logic [NW-1:0]        dmag8_ff;
   logic                 dneg8_ff;
   logic                 ok_in;
   logic                 ok_ff [0:DL];

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         prod_in[j] = '0;
         for (int k = 0; k < K; k++) begin
            prod_in[j] = prod_in[j] + (MW'(pp_ff[j][k]) <<< (k * CH));
         end
      end
      ok_in = !side_ff[7].degen && (dmag7_ff > NW'({thr_ff, {DENOM_SHIFT{1'b0}}}));
   end

   // ---------------- payload registers of the front stages ----------------
   always_ff @(posedge clock) begin
      side_ff[1] <= s1_in;
      a1_ff      <= a1_in;
      side_ff[2] <= s2_in;
      prd_ff     <= prd_in;
      for (int s = 3; s <= 8; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
      dot_ff     <= dot_in;
      hh_ff      <= hh_in;
      hl_ff      <= hl_in;
      lh_ff      <= lh_in;
      ll_ff      <= ll_in;
      cross_ff   <= cross_in;
      denom6_ff  <= NW'(cross_ff[0]) - NW'(cross_ff[1]);
      numa6_ff   <= NW'(cross_ff[2]) - NW'(cross_ff[3]);
      numb6_ff   <= NW'(cross_ff[4]) - NW'(cross_ff[5]);
      dmag7_ff   <= denom6_ff[NW-1] ? (~denom6_ff + 1'b1) : denom6_ff;
      dneg7_ff   <= denom6_ff[NW-1];
      numa7_ff   <= numa6_ff;
      numb7_ff   <= numb6_ff;
      pp_ff      <= pp_in;
      prod_ff    <= prod_in;
      npar_ff[0] <= MW'(numa7_ff) <<< FRAC_BITS;
      npar_ff[1] <= MW'(numb7_ff) <<< FRAC_BITS;
      dmag8_ff   <= dmag7_ff;
      dneg8_ff   <= dneg7_ff;
      ok_ff[0]   <= ok_in;
      for (int s = 1; s <= DL; s++) begin
         ok_ff[s] <= ok_ff[s-1];
      end
   end

   // ---------------- dividers ----------------
   // order: near_a x/y/z, near_b x/y/z, param_a, param_b
   logic signed [COORD_WIDTH-1:0] res [8];

   for (genvar d = 0; d < 8; d++) begin : g_div
      logic signed [MW-1:0]          num;
      logic signed [COORD_WIDTH-1:0] offs;

      if (d < 3) begin : g_pa
         assign num  = prod_ff[d];
         assign offs = $signed(side_ff[8].a0[d]);
      end else if (d < 6) begin : g_pb
         assign num  = prod_ff[d];
         assign offs = $signed(side_ff[8].b0[d-3]);
      end else begin : g_par
         assign num  = npar_ff[d-6];
         assign offs = '0;
      end

      llcp_div #(
         .COORD_WIDTH (COORD_WIDTH),
         .NUM_WIDTH   (MW),
         .DEN_WIDTH   (NW)
      ) u_div (
         .clock  (clock),
         .n      (num),
         .dmag   (dmag8_ff),
         .dneg   (dneg8_ff),
         .base   (offs),
         .result (res[d])
      );
   end

   // ---------------- result ----------------
   logic res_ok;

   assign res_ok        = ok_ff[DL];
   assign rsp_valid     = vld_ff[NREG-1];
   assign rsp_valid_res = rsp_valid && res_ok;
   assign rsp_near_a_x  = res_ok ? res[0] : '0;
   assign rsp_near_a_y  = res_ok ? res[1] : '0;
   assign rsp_near_a_z  = res_ok ? res[2] : '0;
   assign rsp_near_b_x  = res_ok ? res[3] : '0;
   assign rsp_near_b_y  = res_ok ? res[4] : '0;
   assign rsp_near_b_z  = res_ok ? res[5] : '0;
   assign rsp_param_a   = res_ok ? res[6] : '0;
   assign rsp_param_b   = res_ok ? res[7] : '0;

   // ---------------- assertions ----------------
   `LLCP_ASSERT_DELAY(a_accept_to_result, clock, reset, start && !busy, NREG, rsp_valid, "accepted transaction produced no result at the pipeline latency")
   `LLCP_ASSERT_IMPLIES(a_res_only_with_strobe, clock, reset, rsp_valid_res, rsp_valid, "valid_res raised outside a result strobe")
   `LLCP_ASSERT_IMPLIES(a_invalid_zero, clock, reset, rsp_valid && !rsp_valid_res, (rsp_param_a == '0) && (rsp_param_b == '0) && (rsp_near_a_x == '0) && (rsp_near_b_z == '0), "invalid result carries nonzero fields")
endmodule
